### design/thc_pkg.sv
// Shared types and constants for the thermistor and humidity conversion block.
// No dependencies; every module of the block imports it.
package thc_pkg;

   localparam int ADC_BITS = 12;
   localparam logic [ADC_BITS-1:0] FULL_SCALE = {ADC_BITS{1'b1}};

   localparam int CB_W  = ADC_BITS + 24;
   localparam int HALF  = CB_W / 2;
   localparam int NUM_W = CB_W + 24;
   localparam int DEN_W = ADC_BITS + 26;

   localparam logic [3:0] RANGE_0 = 4'd0;
   localparam logic [3:0] RANGE_1 = 4'd1;
   localparam logic [3:0] RANGE_2 = 4'd2;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS0   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS1   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS2   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SHUNT1  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SHUNT2  = 3'd6;

   localparam logic [29:0] LN2_Q30      = 30'd744261118;
   localparam int          KELVIN_CENTI = 27315;
   localparam logic [15:0] MAX_CENTI_K  = 16'd57315;
   localparam logic [21:0] BETA_SCALE   = 22'd2731500;
   localparam int          HUM_K0       = 1000000;
   localparam logic [15:0] HUM_OFFSET   = 16'd44775;
   localparam logic [15:0] HUM_TOP      = 16'd54775;
   localparam logic [13:0] HUM_MAX      = 14'd10000;

   localparam int LOG_W     = 30;
   localparam int SQ_STEPS  = 24;
   localparam int LOG_LAT   = SQ_STEPS + 2;
   localparam int QBITS     = 16;
   localparam int DIV_LAT   = QBITS + 1;
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 48;
   localparam int NST       = 4 + LOG_LAT + 6 + DIV_LAT + 4 + DIV_LAT;

   typedef struct packed {
      logic [11:0] adc_code;
      logic [3:0]  range_select;
      logic [23:0] humidity_count;
      logic [23:0] humidity_reference;
   } req_type;

   typedef struct packed {
      logic signed [15:0] temp_centi_c;
      logic               temp_valid;
      logic [13:0]        humidity_centi_pct;
      logic               humidity_valid;
   } rsp_type;

   typedef struct packed {
      logic        tv;
      logic [23:0] cnt;
      logic [23:0] hum_ref;
   } tsb_type;

   typedef struct packed {
      logic signed [15:0] tc;
      logic               tv;
      logic               hv;
   } hsb_type;

endpackage

### design/thc_log2.sv
// Pipelined base-2 logarithm with 24 fraction bits: normalize, then 24 squaring stages.
// Depends on thc_pkg.
module thc_log2
   import thc_pkg::*;
(
   input  logic                 clock,
   input  logic                 adv,
   input  logic [63:0]          x_in,
   output logic [LOG_W-1:0]     log_out
);

   logic [63:0] n1_x_in, n1_x_ff;
   logic [2:0]  n1_lz_in, n1_lz_ff;
   logic [63:0] n2_t;
   logic [2:0]  n2_lz;

   logic [30:0] m_ff    [0:SQ_STEPS];
   logic [23:0] frac_ff [0:SQ_STEPS];
   logic [5:0]  msb_ff  [0:SQ_STEPS];

   always_comb begin
      n1_x_in  = x_in;
      n1_lz_in = '0;
      if (n1_x_in[63:32] == '0) begin
         n1_x_in     = n1_x_in << 32;
         n1_lz_in[2] = 1'b1;
      end
      if (n1_x_in[63:48] == '0) begin
         n1_x_in     = n1_x_in << 16;
         n1_lz_in[1] = 1'b1;
      end
      if (n1_x_in[63:56] == '0) begin
         n1_x_in     = n1_x_in << 8;
         n1_lz_in[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n1_x_ff  <= n1_x_in;
         n1_lz_ff <= n1_lz_in;
      end
   end

   always_comb begin
      n2_t  = n1_x_ff;
      n2_lz = '0;
      if (n2_t[63:60] == '0) begin
         n2_t     = n2_t << 4;
         n2_lz[2] = 1'b1;
      end
      if (n2_t[63:62] == '0) begin
         n2_t     = n2_t << 2;
         n2_lz[1] = 1'b1;
      end
      if (n2_t[63] == 1'b0) begin
         n2_t     = n2_t << 1;
         n2_lz[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff[0]    <= n2_t[63:33];
         frac_ff[0] <= '0;
         msb_ff[0]  <= ~{n1_lz_ff, n2_lz};
      end
   end

   for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
      logic [61:0] prod;
      logic [31:0] sq;
      logic [30:0] m_in;
      assign prod = 62'(m_ff[j]) * 62'(m_ff[j]);
      assign sq   = prod[61:30];
      assign m_in = sq[31] ? sq[31:1] : sq[30:0];
      always_ff @(posedge clock) begin
         if (adv) begin
            m_ff[j+1]    <= m_in;
            frac_ff[j+1] <= {frac_ff[j][22:0], sq[31]};
            msb_ff[j+1]  <= msb_ff[j];
         end
      end
   end

   assign log_out = {msb_ff[SQ_STEPS], frac_ff[SQ_STEPS]};

endmodule

### design/thc_div.sv
// Pipelined restoring divider: 16 quotient bits, one per stage, with overflow flag.
// Depends on thc_pkg.
module thc_div
   import thc_pkg::*;
(
   input  logic                 clock,
   input  logic                 adv,
   input  logic [DIV_NUM_W-1:0] num_in,
   input  logic [DIV_DEN_W-1:0] den_in,
   output logic [QBITS-1:0]     quo_out,
   output logic                 ovf_out
);

   logic [DIV_NUM_W-1:0] r_ff   [0:QBITS];
   logic [DIV_DEN_W-1:0] den_ff [0:QBITS];
   logic [QBITS-1:0]     q_ff   [0:QBITS];
   logic                 ovf_ff [0:QBITS];

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff[0]   <= num_in;
         den_ff[0] <= den_in;
         q_ff[0]   <= '0;
         ovf_ff[0] <= num_in >= (DIV_NUM_W'(den_in) << QBITS);
      end
   end

   for (genvar j = 0; j < QBITS; j++) begin : g_step
      logic [DIV_NUM_W-1:0] dsh;
      logic                 ge;
      logic [DIV_NUM_W-1:0] r_in;
      assign dsh  = DIV_NUM_W'(den_ff[j]) << (QBITS - 1 - j);
      assign ge   = r_ff[j] >= dsh;
      assign r_in = ge ? r_ff[j] - dsh : r_ff[j];
      always_ff @(posedge clock) begin
         if (adv) begin
            r_ff[j+1]   <= r_in;
            den_ff[j+1] <= den_ff[j];
            q_ff[j+1]   <= {q_ff[j][QBITS-2:0], ge};
            ovf_ff[j+1] <= ovf_ff[j];
         end
      end
   end

   assign quo_out = q_ff[QBITS];
   assign ovf_out = ovf_ff[QBITS];

endmodule

### design/thermistor_humidity_conversion.sv
// Thermistor temperature and humidity conversion. One transaction is taken per cycle while
// req_ready is high; the pipeline depth comes from the three 26-stage logarithm pipelines
// and the two 17-stage restoring dividers, one quotient bit a stage.
// A two-entry output register pair holds results when the consumer stalls; the whole
// pipeline then holds, and req_ready drops, until the spare entry drains.
// Configuration writes are taken in any cycle and must only be issued while the block is
// idle. Depends on thc_pkg, thc_log2 and thc_div.
module thermistor_humidity_conversion
   import thc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [23:0]          csr_wdata
);

   logic [13:0] beta_ff;
   logic [19:0] nominal_ff;
   logic [23:0] bias0_ff, bias1_ff, bias2_ff, shunt1_ff, shunt2_ff;

   logic           pipe_adv;
   logic [NST-1:0] vld_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff    <= 14'd3100;
         nominal_ff <= 20'd15000;
         bias0_ff   <= 24'd12100;
         bias1_ff   <= 24'd36500;
         bias2_ff   <= 24'd475000;
         shunt1_ff  <= 24'd330000;
         shunt2_ff  <= 24'd2000000;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BETA:    beta_ff    <= csr_wdata[13:0];
            CSR_NOMINAL: nominal_ff <= csr_wdata[19:0];
            CSR_BIAS0:   bias0_ff   <= csr_wdata;
            CSR_BIAS1:   bias1_ff   <= csr_wdata;
            CSR_BIAS2:   bias2_ff   <= csr_wdata;
            CSR_SHUNT1:  shunt1_ff  <= csr_wdata;
            CSR_SHUNT2:  shunt2_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   // divider front end
   logic [ADC_BITS-1:0] f1_c_ff;
   logic                f1_sel0_ff, f1_selok_ff;
   logic [23:0]         f1_b_ff, f1_p_ff, f1_b_in, f1_p_in;
   logic [23:0]         f1_cnt_ff, f1_ref_ff;
   logic                f1_selok_in;

   always_comb begin
      f1_selok_in = req_data.range_select inside {RANGE_0, RANGE_1, RANGE_2};
      case (req_data.range_select)
         RANGE_0: f1_b_in = bias0_ff;
         RANGE_1: f1_b_in = bias1_ff;
         default: f1_b_in = bias2_ff;
      endcase
      f1_p_in = (req_data.range_select == RANGE_1) ? shunt1_ff : shunt2_ff;
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         f1_c_ff     <= ADC_BITS'(req_data.adc_code);
         f1_sel0_ff  <= req_data.range_select == RANGE_0;
         f1_selok_ff <= f1_selok_in;
         f1_b_ff     <= f1_b_in;
         f1_p_ff     <= f1_p_in;
         f1_cnt_ff   <= req_data.humidity_count;
         f1_ref_ff   <= req_data.humidity_reference;
      end
   end

   logic [CB_W-1:0]     f2_cb_ff, f2_fsp_ff;
   logic [CB_W:0]       f2_cbs_ff;
   logic [ADC_BITS-1:0] f2_d0_ff;
   logic [23:0]         f2_p_ff, f2_cnt_ff, f2_ref_ff;
   logic                f2_nz_ff, f2_sel0_ff, f2_selok_ff;

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         f2_cb_ff    <= CB_W'(f1_c_ff) * CB_W'(f1_b_ff);
         f2_fsp_ff   <= CB_W'(f1_p_ff) * CB_W'(FULL_SCALE);
         f2_cbs_ff   <= (CB_W + 1)'(f1_c_ff) * ((CB_W + 1)'(f1_b_ff) + (CB_W + 1)'(f1_p_ff));
         f2_d0_ff    <= FULL_SCALE - f1_c_ff;
         f2_p_ff     <= f1_p_ff;
         f2_nz_ff    <= (f1_c_ff != '0) && (f1_b_ff != '0) && (f1_sel0_ff || f1_p_ff != '0);
         f2_sel0_ff  <= f1_sel0_ff;
         f2_selok_ff <= f1_selok_ff;
         f2_cnt_ff   <= f1_cnt_ff;
         f2_ref_ff   <= f1_ref_ff;
      end
   end

   logic [HALF+23:0]        f3_pplo_ff;
   logic [CB_W-HALF+23:0]   f3_pphi_ff;
   logic [CB_W-1:0]         f3_cb_ff;
   logic signed [DEN_W-1:0] f3_den_ff;
   logic [23:0]             f3_cnt_ff, f3_ref_ff;
   logic                    f3_nz_ff, f3_sel0_ff, f3_selok_ff;

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         f3_pplo_ff  <= (HALF + 24)'(f2_cb_ff[HALF-1:0]) * (HALF + 24)'(f2_p_ff);
         f3_pphi_ff  <= (CB_W - HALF + 24)'(f2_cb_ff[CB_W-1:HALF])
                        * (CB_W - HALF + 24)'(f2_p_ff);
         f3_cb_ff    <= f2_cb_ff;
         f3_den_ff   <= f2_sel0_ff ? DEN_W'(f2_d0_ff) : DEN_W'(f2_fsp_ff) - DEN_W'(f2_cbs_ff);
         f3_nz_ff    <= f2_nz_ff;
         f3_sel0_ff  <= f2_sel0_ff;
         f3_selok_ff <= f2_selok_ff;
         f3_cnt_ff   <= f2_cnt_ff;
         f3_ref_ff   <= f2_ref_ff;
      end
   end

   logic [NUM_W-1:0]   f4_num_ff;
   logic [DEN_W-2:0]   f4_den_ff;
   tsb_type            f4_sb_ff;

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         f4_num_ff   <= f3_sel0_ff ? NUM_W'(f3_cb_ff)
                        : NUM_W'(f3_pplo_ff) + (NUM_W'(f3_pphi_ff) << HALF);
         f4_den_ff   <= f3_den_ff[DEN_W-2:0];
         f4_sb_ff.tv <= f3_selok_ff && f3_nz_ff && (f3_den_ff > 0) && (nominal_ff != '0);
         f4_sb_ff.cnt     <= f3_cnt_ff;
         f4_sb_ff.hum_ref <= f3_ref_ff;
      end
   end

   // logarithms
   logic [LOG_W-1:0] lg_num, lg_den, lg_nom;

   thc_log2 u_log_num (
      .clock   (clock),
      .adv     (pipe_adv),
      .x_in    (64'(f4_num_ff)),
      .log_out (lg_num)
   );

   thc_log2 u_log_den (
      .clock   (clock),
      .adv     (pipe_adv),
      .x_in    (64'(f4_den_ff)),
      .log_out (lg_den)
   );

   thc_log2 u_log_nom (
      .clock   (clock),
      .adv     (pipe_adv),
      .x_in    (64'(nominal_ff)),
      .log_out (lg_nom)
   );

   tsb_type lsb_ff [0:LOG_LAT-1];

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         lsb_ff[0] <= f4_sb_ff;
         for (int i = 1; i < LOG_LAT; i++) begin
            lsb_ff[i] <= lsb_ff[i-1];
         end
      end
   end

   // beta equation
   logic signed [31:0] p1_l_ff;
   tsb_type            p1_sb_ff;
   logic               p2_neg_ff;
   logic [60:0]        p2_prod_ff;
   tsb_type            p2_sb_ff;
   logic signed [31:0] p3_lnq_ff;
   tsb_type            p3_sb_ff;
   logic signed [47:0] p4_t1_ff;
   logic [20:0]        p4_t2_ff;
   tsb_type            p4_sb_ff;
   logic signed [47:0] p5_dq_ff;
   logic [35:0]        p5_n_ff;
   tsb_type            p5_sb_ff;
   logic [DIV_NUM_W-1:0] p6_num_ff;
   logic [DIV_DEN_W-1:0] p6_den_ff;
   tsb_type            p6_sb_ff;

   logic signed [31:0] p2_abs;
   logic [30:0]        p3_mag;

   assign p2_abs = p1_l_ff[31] ? -p1_l_ff : p1_l_ff;
   assign p3_mag = 31'((p2_prod_ff + 61'(1 << 29)) >> 30);

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         p1_l_ff    <= $signed(32'(lg_num)) - $signed(32'(lg_den)) - $signed(32'(lg_nom));
         p1_sb_ff   <= lsb_ff[LOG_LAT-1];
         p2_neg_ff  <= p1_l_ff[31];
         p2_prod_ff <= 61'(p2_abs[30:0]) * 61'(LN2_Q30);
         p2_sb_ff   <= p1_sb_ff;
         p3_lnq_ff  <= p2_neg_ff ? -$signed(32'(p3_mag)) : $signed(32'(p3_mag));
         p3_sb_ff   <= p2_sb_ff;
         p4_t1_ff   <= 48'(p3_lnq_ff) * 48'(KELVIN_CENTI);
         p4_t2_ff   <= 21'(beta_ff) * 21'(100);
         p4_sb_ff   <= p3_sb_ff;
         p5_dq_ff   <= p4_t1_ff + $signed({3'b000, p4_t2_ff, 24'd0});
         p5_n_ff    <= 36'(beta_ff) * 36'(BETA_SCALE);
         p5_sb_ff   <= p4_sb_ff;
         p6_num_ff  <= DIV_NUM_W'({p5_n_ff, 24'd0}) + DIV_NUM_W'(p5_dq_ff[46:1]);
         p6_den_ff  <= p5_dq_ff[DIV_DEN_W-1:0];
         p6_sb_ff.tv      <= p5_sb_ff.tv && (p5_dq_ff > 0);
         p6_sb_ff.cnt     <= p5_sb_ff.cnt;
         p6_sb_ff.hum_ref <= p5_sb_ff.hum_ref;
      end
   end

   logic [QBITS-1:0] tq;
   logic             tovf;

   thc_div u_div_temp (
      .clock   (clock),
      .adv     (pipe_adv),
      .num_in  (p6_num_ff),
      .den_in  (p6_den_ff),
      .quo_out (tq),
      .ovf_out (tovf)
   );

   tsb_type dsb_ff [0:DIV_LAT-1];

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         dsb_ff[0] <= p6_sb_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            dsb_ff[i] <= dsb_ff[i-1];
         end
      end
   end

   // humidity
   tsb_type            dsb_out;
   logic [15:0]        p7_tk;
   logic signed [16:0] p7_tc_full;
   logic signed [15:0] p7_tc_ff;
   logic               p7_tv_ff;
   logic [23:0]        p7_cnt_ff, p7_ref_ff;
   logic signed [21:0] p8_k_full;
   logic [20:0]        p8_k_ff;
   logic [28:0]        p8_d_ff;
   logic [23:0]        p8_cnt_ff;
   hsb_type            p8_sb_ff;
   logic [44:0]        p9_prod_ff;
   logic [28:0]        p9_d_ff;
   hsb_type            p9_sb_ff;
   logic [DIV_NUM_W-1:0] p10_num_ff;
   logic [DIV_DEN_W-1:0] p10_den_ff;
   hsb_type            p10_sb_ff;

   assign dsb_out    = dsb_ff[DIV_LAT-1];
   assign p7_tk      = (tovf || tq > MAX_CENTI_K) ? MAX_CENTI_K : tq;
   assign p7_tc_full = $signed(17'(p7_tk)) - 17'(KELVIN_CENTI);
   assign p8_k_full  = 22'(HUM_K0) - (22'(p7_tc_ff) <<< 2);

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         p7_tc_ff    <= dsb_out.tv ? p7_tc_full[15:0] : '0;
         p7_tv_ff    <= dsb_out.tv;
         p7_cnt_ff   <= dsb_out.cnt;
         p7_ref_ff   <= dsb_out.hum_ref;
         p8_k_ff     <= p8_k_full[20:0];
         p8_d_ff     <= 29'(p7_ref_ff) * 29'(20);
         p8_cnt_ff   <= p7_cnt_ff;
         p8_sb_ff.tc <= p7_tc_ff;
         p8_sb_ff.tv <= p7_tv_ff;
         p8_sb_ff.hv <= p7_tv_ff && (p7_ref_ff != '0);
         p9_prod_ff  <= 45'(p8_cnt_ff) * 45'(p8_k_ff);
         p9_d_ff     <= p8_d_ff;
         p9_sb_ff    <= p8_sb_ff;
         p10_num_ff  <= DIV_NUM_W'(p9_prod_ff) + DIV_NUM_W'(p9_d_ff[28:1]);
         p10_den_ff  <= DIV_DEN_W'(p9_d_ff);
         p10_sb_ff   <= p9_sb_ff;
      end
   end

   logic [QBITS-1:0] hq;
   logic             hovf;

   thc_div u_div_hum (
      .clock   (clock),
      .adv     (pipe_adv),
      .num_in  (p10_num_ff),
      .den_in  (p10_den_ff),
      .quo_out (hq),
      .ovf_out (hovf)
   );

   hsb_type hsb_ff [0:DIV_LAT-1];

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         hsb_ff[0] <= p10_sb_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            hsb_ff[i] <= hsb_ff[i-1];
         end
      end
   end

   // result assembly and output register pair
   hsb_type     hsb_out;
   logic [13:0] hum;
   rsp_type     res;

   assign hsb_out = hsb_ff[DIV_LAT-1];

   always_comb begin
      if (hovf || hq >= HUM_TOP) begin
         hum = HUM_MAX;
      end else if (hq < HUM_OFFSET) begin
         hum = '0;
      end else begin
         hum = 14'(hq - HUM_OFFSET);
      end
      res.temp_centi_c       = hsb_out.tc;
      res.temp_valid         = hsb_out.tv;
      res.humidity_centi_pct = hsb_out.hv ? hum : '0;
      res.humidity_valid     = hsb_out.hv;
   end

   logic    out_vld_ff, skid_vld_ff;
   rsp_type out_ff, skid_ff;
   logic    take, tail;

   assign pipe_adv  = !skid_vld_ff;
   assign req_ready = pipe_adv;
   assign take      = out_vld_ff && rsp_ready;
   assign tail      = vld_ff[NST-1] && pipe_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (take) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (tail) begin
         if (!out_vld_ff || take) begin
            out_vld_ff <= 1'b1;
         end else begin
            skid_vld_ff <= 1'b1;
         end
      end else if (take) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (tail) begin
         if (!out_vld_ff || take) begin
            out_ff <= res;
         end else begin
            skid_ff <= res;
         end
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   assert property (@(posedge clock) disable iff (reset) skid_vld_ff |-> out_vld_ff)
      else $error("spare result entry holds data while the output entry is empty");

   assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(out_vld_ff && !rsp_ready))
      else $error("spare result entry filled while the output was free");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.temp_valid |->
      rsp_data.temp_centi_c == '0 && !rsp_data.humidity_valid)
      else $error("invalid temperature with nonzero value or valid humidity");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.humidity_centi_pct <= HUM_MAX &&
      rsp_data.temp_centi_c >= -16'sd27315 && rsp_data.temp_centi_c <= 16'sd30000)
      else $error("result out of range");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for thermistor_humidity_conversion: an integer predictor of the
// temperature and humidity conversion checks every result transaction in order.
// Depends on thc_pkg and the RTL of the block.
module tb_top;
   import thc_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BETA;
   logic [23:0]          csr_wdata = '0;

   int      errors = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   rsp_type expected_readings[$];
   longint  beta_k, nominal_r, bias_r[3], shunt_r[3];

   thermistor_humidity_conversion i_dut (.*);

   always #5 clock = ~clock;

   function automatic longint log2_fixed(longint unsigned x);
      int             msb;
      longint unsigned m;
      longint          frac;
      msb = 63;
      frac = 0;
      while (msb > 0 && x[msb] == 1'b0) msb--;
      m = (msb >= 30) ? (x >> (msb - 30)) : (x << (30 - msb));
      for (int i = 0; i < 24; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= 64'h8000_0000) begin
            frac = frac | 1;
            m = m >> 1;
         end
      end
      return longint'(msb) * 16777216 + frac;
   endfunction

   function automatic rsp_type convert_reading(req_type r);
      rsp_type         o;
      longint          c, cnt, hr, den, b, p, l2, lnq, dq, tk, tc, hum, k, d, v;
      longint unsigned num;
      bit              tv;
      c = r.adc_code;
      cnt = r.humidity_count;
      hr = r.humidity_reference;
      tv = 1'b1;
      tc = 0;
      hum = 0;
      num = 0;
      den = 0;
      if (r.range_select == RANGE_0) begin
         num = c * bias_r[0];
         den = 4095 - c;
      end else if (r.range_select == RANGE_1 || r.range_select == RANGE_2) begin
         b = bias_r[r.range_select];
         p = shunt_r[r.range_select];
         num = longint'(c) * b * p;
         den = 4095 * p - c * (b + p);
      end else begin
         tv = 1'b0;
      end
      if (tv && (num == 0 || den <= 0 || nominal_r == 0)) tv = 1'b0;
      if (tv) begin
         l2 = log2_fixed(num) - log2_fixed(den) - log2_fixed(nominal_r);
         v = l2 * 744261118;
         lnq = (v < 0) ? -(((-v) + (64'sd1 << 29)) >>> 30) : ((v + (64'sd1 << 29)) >>> 30);
         dq = 27315 * lnq + beta_k * 100 * 16777216;
         if (dq <= 0) begin
            tv = 1'b0;
         end else begin
            tk = (beta_k * 2731500 * 16777216 + dq / 2) / dq;
            if (tk > 57315) tk = 57315;
            tc = tk - 27315;
         end
      end
      o.humidity_valid = 1'b0;
      if (tv && hr != 0) begin
         k = 1000000 - 4 * tc;
         d = 20 * hr;
         hum = (cnt * k + d / 2) / d - 44775;
         if (hum < 0) hum = 0;
         if (hum > 10000) hum = 10000;
         o.humidity_valid = 1'b1;
      end
      o.temp_centi_c = tc[15:0];
      o.temp_valid = tv;
      o.humidity_centi_pct = hum[13:0];
      return o;
   endfunction

   task automatic send_reading(req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= r;
      expected_readings.push_back(convert_reading(r));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, longint val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[23:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_BETA:    beta_k = val & 14'h3FFF;
         CSR_NOMINAL: nominal_r = val & 20'hFFFFF;
         CSR_BIAS0:   bias_r[0] = val & 24'hFFFFFF;
         CSR_BIAS1:   bias_r[1] = val & 24'hFFFFFF;
         CSR_BIAS2:   bias_r[2] = val & 24'hFFFFFF;
         CSR_SHUNT1:  shunt_r[1] = val & 24'hFFFFFF;
         CSR_SHUNT2:  shunt_r[2] = val & 24'hFFFFFF;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic send_fields(int code, int sel, int cnt, int hr);
      req_type r;
      r.adc_code = 12'(code);
      r.range_select = 4'(sel);
      r.humidity_count = 24'(cnt);
      r.humidity_reference = 24'(hr);
      send_reading(r);
   endtask

   function automatic req_type random_reading();
      req_type r;
      int      kind;
      kind = $urandom_range(99);
      r.adc_code = (kind < 5) ? (($urandom_range(1) != 0) ? 12'hFFF : 12'h0) : 12'($urandom);
      r.range_select = (kind < 90) ? 4'($urandom_range(2)) : 4'($urandom);
      r.humidity_reference = ($urandom_range(19) == 0) ? 24'h0 : 24'($urandom);
      if ($urandom_range(3) == 0) r.humidity_count = 24'($urandom);
      else r.humidity_count = 24'((longint'(r.humidity_reference)
                                   * $urandom_range(800, 1100)) / 1000);
      return r;
   endfunction

   task automatic test_directed();
      send_fields(0, 0, 100000, 100000);
      send_fields(4095, 0, 100000, 100000);
      send_fields(2048, 0, 16777215, 16777215);
      send_fields(2048, 1, 9000000, 10000000);
      send_fields(2048, 2, 9000000, 10000000);
      send_fields(4095, 1, 1, 1);
      send_fields(4095, 2, 16777215, 1);
      send_fields(1, 0, 0, 16777215);
      send_fields(1, 2, 5000000, 5000000);
      send_fields(2048, 3, 100000, 100000);
      send_fields(2048, 15, 100000, 100000);
      send_fields(2048, 0, 100000, 0);
      send_fields(4000, 0, 16777215, 16777215);
      send_fields(30, 0, 0, 1);
      send_fields(3000, 1, 0, 16777215);
      drain();
   endtask

   task automatic test_config_extremes();
      write_csr(CSR_BETA, 10000);
      write_csr(CSR_NOMINAL, 1000);
      write_csr(CSR_BIAS0, 10000000);
      write_csr(CSR_BIAS1, 100);
      write_csr(CSR_BIAS2, 10000000);
      write_csr(CSR_SHUNT1, 10000000);
      write_csr(CSR_SHUNT2, 100);
      for (int i = 0; i < 100; i++) send_reading(random_reading());
      drain();
      write_csr(CSR_BETA, 1000);
      write_csr(CSR_NOMINAL, 1000000);
      write_csr(CSR_BIAS0, 100);
      write_csr(CSR_BIAS1, 10000000);
      write_csr(CSR_BIAS2, 100);
      write_csr(CSR_SHUNT1, 100);
      write_csr(CSR_SHUNT2, 10000000);
      for (int i = 0; i < 100; i++) send_reading(random_reading());
      drain();
      write_csr(CSR_BETA, 0);
      write_csr(CSR_NOMINAL, 0);
      write_csr(CSR_BIAS0, 0);
      send_fields(2000, 0, 100, 100);
      send_fields(2000, 1, 100, 100);
      drain();
      write_csr(CSR_BETA, 16383);
      write_csr(CSR_NOMINAL, 1048575);
      write_csr(CSR_BIAS0, 16777215);
      write_csr(CSR_BIAS1, 16777215);
      write_csr(CSR_BIAS2, 16777215);
      write_csr(CSR_SHUNT1, 16777215);
      write_csr(CSR_SHUNT2, 16777215);
      for (int i = 0; i < 100; i++) send_reading(random_reading());
      drain();
   endtask

   task automatic test_random_traffic();
      int sends[4] = '{0, 72, 0, 19};
      int stalls[4] = '{0, 0, 72, 19};
      for (int ph = 0; ph < 4; ph++) begin
         write_csr(CSR_BETA, ($urandom_range(1) != 0) ? 3100 : 3450);
         write_csr(CSR_NOMINAL, $urandom_range(5000, 50000));
         write_csr(CSR_BIAS0, $urandom_range(1000, 100000));
         write_csr(CSR_BIAS1, $urandom_range(10000, 200000));
         write_csr(CSR_BIAS2, $urandom_range(100000, 1000000));
         write_csr(CSR_SHUNT1, $urandom_range(100000, 1000000));
         write_csr(CSR_SHUNT2, $urandom_range(1000000, 4000000));
         send_idle_pct = sends[ph];
         recv_stall_pct = stalls[ph];
         for (int i = 0; i < 425; i++) begin
            send_reading(random_reading());
            if (ph == 1 && i == 200) drain();
         end
         drain();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) begin
            $display("%0t: unexpected result %p", $realtime, rsp_data);
            errors++;
         end else begin
            rsp_type w;
            w = expected_readings.pop_front();
            if (w.temp_centi_c !== rsp_data.temp_centi_c)
               $display("%0t: temp_centi_c expected %0d actual %0d", $realtime,
                        w.temp_centi_c, rsp_data.temp_centi_c);
            if (w.temp_valid !== rsp_data.temp_valid)
               $display("%0t: temp_valid expected %0b actual %0b", $realtime,
                        w.temp_valid, rsp_data.temp_valid);
            if (w.humidity_centi_pct !== rsp_data.humidity_centi_pct)
               $display("%0t: humidity_centi_pct expected %0d actual %0d", $realtime,
                        w.humidity_centi_pct, rsp_data.humidity_centi_pct);
            if (w.humidity_valid !== rsp_data.humidity_valid)
               $display("%0t: humidity_valid expected %0b actual %0b", $realtime,
                        w.humidity_valid, rsp_data.humidity_valid);
            if (w !== rsp_data) errors++;
         end
      end
   end

   initial begin
      beta_k = 3100;
      nominal_r = 15000;
      bias_r = '{12100, 36500, 475000};
      shunt_r = '{0, 330000, 2000000};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      test_random_traffic();
      if (errors == 0 && expected_readings.size() == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
